// ----- src/sc1a_pkg.sv -----
package sc1a_pkg;

	localparam int unsigned ScanWidth = 8;
	localparam int unsigned CodeWidth = 7;
	localparam int unsigned CharWidth = 7;

	// Key codes with modifier meaning (break bit stripped)
	localparam logic [CodeWidth-1:0] KEY_LSHIFT = 7'h2a;
	localparam logic [CodeWidth-1:0] KEY_RSHIFT = 7'h36;
	localparam logic [CodeWidth-1:0] KEY_CTRL   = 7'h1d;
	localparam logic [CodeWidth-1:0] KEY_CAPS   = 7'h3a;
	localparam logic [CodeWidth-1:0] KEY_ALT    = 7'h38;

	localparam logic [CharWidth-1:0] CHAR_LOW_A = 7'h61;
	localparam logic [CharWidth-1:0] CHAR_LOW_Z = 7'h7a;

	typedef struct packed {
		logic [CharWidth-1:0] lower;
		logic [CharWidth-1:0] upper;
	} rom_entry_t;

	// Translation result for one scan word
	typedef struct packed {
		logic                 emit;
		logic [CharWidth-1:0] char_code;
		logic                 ctrl_held;
		logic                 alt_held;
	} sc1a_result_t;

	// Two-column ASCII table; codes past the table read as zero
	function automatic rom_entry_t ascii_rom(input logic [CodeWidth-1:0] code);
		rom_entry_t e;
		e = '{lower: 7'h00, upper: 7'h00};
		case (code)
			7'd1:  e = '{7'h5e, 7'h5e};
			7'd2:  e = '{7'h31, 7'h21};
			7'd3:  e = '{7'h32, 7'h40};
			7'd4:  e = '{7'h33, 7'h23};
			7'd5:  e = '{7'h34, 7'h24};
			7'd6:  e = '{7'h35, 7'h25};
			7'd7:  e = '{7'h36, 7'h5e};
			7'd8:  e = '{7'h37, 7'h26};
			7'd9:  e = '{7'h38, 7'h2a};
			7'd10: e = '{7'h39, 7'h28};
			7'd11: e = '{7'h30, 7'h29};
			7'd12: e = '{7'h2d, 7'h5f};
			7'd13: e = '{7'h3d, 7'h2b};
			7'd15: e = '{7'h09, 7'h09};
			7'd16: e = '{7'h71, 7'h51};
			7'd17: e = '{7'h77, 7'h57};
			7'd18: e = '{7'h65, 7'h45};
			7'd19: e = '{7'h72, 7'h52};
			7'd20: e = '{7'h74, 7'h54};
			7'd21: e = '{7'h79, 7'h59};
			7'd22: e = '{7'h75, 7'h55};
			7'd23: e = '{7'h69, 7'h49};
			7'd24: e = '{7'h6f, 7'h4f};
			7'd25: e = '{7'h70, 7'h50};
			7'd26: e = '{7'h5b, 7'h7b};
			7'd27: e = '{7'h5d, 7'h7d};
			7'd28: e = '{7'h0a, 7'h0a};
			7'd30: e = '{7'h61, 7'h41};
			7'd31: e = '{7'h73, 7'h53};
			7'd32: e = '{7'h64, 7'h44};
			7'd33: e = '{7'h66, 7'h46};
			7'd34: e = '{7'h67, 7'h47};
			7'd35: e = '{7'h68, 7'h48};
			7'd36: e = '{7'h6a, 7'h4a};
			7'd37: e = '{7'h6b, 7'h4b};
			7'd38: e = '{7'h6c, 7'h4c};
			7'd39: e = '{7'h3b, 7'h3a};
			7'd40: e = '{7'h27, 7'h22};
			7'd41: e = '{7'h60, 7'h7e};
			7'd43: e = '{7'h5c, 7'h7c};
			7'd44: e = '{7'h7a, 7'h5a};
			7'd45: e = '{7'h78, 7'h58};
			7'd46: e = '{7'h63, 7'h43};
			7'd47: e = '{7'h76, 7'h56};
			7'd48: e = '{7'h62, 7'h42};
			7'd49: e = '{7'h6e, 7'h4e};
			7'd50: e = '{7'h6d, 7'h4d};
			7'd51: e = '{7'h2c, 7'h3c};
			7'd52: e = '{7'h2e, 7'h3e};
			7'd53: e = '{7'h2f, 7'h3f};
			7'd55: e = '{7'h2a, 7'h2a};
			7'd57: e = '{7'h20, 7'h20};
			7'd71: e = '{7'h37, 7'h37};
			7'd72: e = '{7'h38, 7'h38};
			7'd73: e = '{7'h39, 7'h39};
			7'd74: e = '{7'h2d, 7'h2d};
			7'd75: e = '{7'h34, 7'h34};
			7'd76: e = '{7'h35, 7'h35};
			7'd77: e = '{7'h36, 7'h36};
			7'd78: e = '{7'h2b, 7'h2b};
			7'd79: e = '{7'h31, 7'h31};
			7'd80: e = '{7'h32, 7'h32};
			7'd81: e = '{7'h33, 7'h33};
			7'd82: e = '{7'h30, 7'h30};
			7'd83: e = '{7'h2e, 7'h2e};
			default: e = '{7'h00, 7'h00};
		endcase
		return e;
	endfunction

endpackage

// ----- src/sc1a_scan_if.sv -----
interface sc1a_scan_if
	import sc1a_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [ScanWidth-1:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

// ----- src/sc1a_char_if.sv -----
interface sc1a_char_if
	import sc1a_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CharWidth-1:0] char_code;
	logic                 ctrl_held;
	logic                 alt_held;

	modport source (output valid, output char_code, output ctrl_held, output alt_held,
		input ready);
	modport sink (input valid, input char_code, input ctrl_held, input alt_held,
		output ready);
endinterface

// ----- src/scancode_set1_to_ascii_unit.sv -----
// Set-1 scan code to ASCII translator.
// A scan word is held in the input register, looked up, and its result word is
// registered in the result register; words that emit no character leave none.
// Throughput: one scan word per cycle; the input register, one table lookup
// and the result register make a two-stage pipe that stalls only on output back-pressure.
// Reset (arst_n low, asynchronous) clears both stage valids and all modifier flags.
module scancode_set1_to_ascii_unit
	import sc1a_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sc1a_scan_if.sink   scan,
	sc1a_char_if.source chars
);

	logic                 valid_s1;
	logic [ScanWidth-1:0] byte_s1;
	logic                 valid_s2;
	sc1a_result_t         res_s2;
	sc1a_result_t         res;
	logic                 s2_free;
	logic                 advance;

	// Stage 2 takes a new word when empty or being drained
	assign s2_free    = ~valid_s2 | chars.ready;
	assign advance    = valid_s1 & s2_free;
	assign scan.ready = ~valid_s1 | s2_free;

	sc1a_xlate u_xlate (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.scan_byte (byte_s1),
		.res       (res)
	);

	// Hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (scan.valid && scan.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= advance & res.emit;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			byte_s1 <= scan.scan_byte;
		end
		if (s2_free) begin
			res_s2 <= res;
		end
	end

	assign chars.valid     = valid_s2;
	assign chars.char_code = res_s2.char_code;
	assign chars.ctrl_held = res_s2.ctrl_held;
	assign chars.alt_held  = res_s2.alt_held;

endmodule

// ----- src/sc1a_xlate.sv -----
module sc1a_xlate
	import sc1a_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [ScanWidth-1:0] scan_byte,
	output sc1a_result_t         res
);

	logic                 shift_q;
	logic                 ctrl_q;
	logic                 alt_q;
	logic                 caps_q;
	logic                 shift_d;
	logic                 ctrl_d;
	logic                 alt_d;
	logic                 caps_d;
	logic                 is_break;
	logic [CodeWidth-1:0] code;
	rom_entry_t           entry;
	logic                 is_letter;
	logic                 use_upper;

	assign is_break = scan_byte[ScanWidth-1];
	assign code     = scan_byte[CodeWidth-1:0];

	// Look up the character; caps lock flips the column for letters
	assign entry     = ascii_rom(code);
	assign is_letter = (entry.lower >= CHAR_LOW_A) && (entry.lower <= CHAR_LOW_Z);
	assign use_upper = shift_q ^ (caps_q & is_letter);

	// Decode modifier keys and decide whether a word goes out
	always_comb begin
		shift_d       = shift_q;
		ctrl_d        = ctrl_q;
		alt_d         = alt_q;
		caps_d        = caps_q;
		res.emit      = 1'b0;
		res.char_code = use_upper ? entry.upper : entry.lower;
		res.ctrl_held = ctrl_q;
		res.alt_held  = alt_q;
		unique case (code) inside
			KEY_LSHIFT, KEY_RSHIFT: shift_d = ~shift_q;
			KEY_CTRL:               ctrl_d  = ~ctrl_q;
			KEY_CAPS:               caps_d  = caps_q ^ is_break;
			KEY_ALT:                alt_d   = ~is_break;
			default:                res.emit = ~is_break;
		endcase
	end

	// Advance the modifier flags once per consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			caps_q  <= 1'b0;
		end else if (step) begin
			shift_q <= shift_d;
			ctrl_q  <= ctrl_d;
			alt_q   <= alt_d;
			caps_q  <= caps_d;
		end
	end

endmodule

// ----- test/testbench.sv -----
module testbench;
	import sc1a_pkg::*;

	localparam int BreakBit    = ScanWidth - 1;
	localparam int RomDepth    = 89;
	localparam int HoldCycles  = 60;
	localparam int DrainCycles = 6;
	localparam int CycleLimit  = 400000;
	localparam int RandomKeys  = 1150;

	typedef struct packed {
		logic [CharWidth-1:0] char_code;
		logic                 ctrl_held;
		logic                 alt_held;
	} key_char_t;

	// Two-column key table, unshifted and shifted
	logic [CharWidth-1:0] lower_col [0:RomDepth-1] = '{
		7'h00, 7'h5e, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
		7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};
	logic [CharWidth-1:0] upper_col [0:RomDepth-1] = '{
		7'h00, 7'h5e, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
		7'h28, 7'h29, 7'h5f, 7'h2b, 7'h00, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
		7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic shift_on = 1'b0;
	logic ctrl_on  = 1'b0;
	logic alt_on   = 1'b0;
	logic caps_on  = 1'b0;

	key_char_t expected_chars[$];
	int        mismatches    = 0;
	int        cycle_count   = 0;
	bit        sender_calm   = 1'b0;
	bit        receiver_calm = 1'b0;
	int        hold_req      = 0;
	int        hold_seen     = 0;
	int        hold_left     = 0;

	sc1a_scan_if scan_bus ();
	sc1a_char_if char_bus ();

	scancode_set1_to_ascii_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_bus),
		.chars  (char_bus)
	);

	always #10 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Update the modifier flags and queue the character a scan word produces
	function automatic void translate_scan(input logic [ScanWidth-1:0] scan);
		logic [CodeWidth-1:0] code;
		logic                 released;
		logic                 use_upper;
		logic [CharWidth-1:0] lower;
		key_char_t            res;
		code = scan[CodeWidth-1:0];
		released = scan[BreakBit];
		if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
			shift_on = !shift_on;
		end else if (code == KEY_CTRL) begin
			ctrl_on = !ctrl_on;
		end else if (code == KEY_CAPS) begin
			if (released)
				caps_on = !caps_on;
		end else if (code == KEY_ALT) begin
			alt_on = !released;
		end else if (!released) begin
			res.char_code = '0;
			if (code < RomDepth) begin
				lower = lower_col[code];
				use_upper = shift_on;
				// caps lock flips the column for letters only
				if (caps_on && lower >= CHAR_LOW_A && lower <= CHAR_LOW_Z)
					use_upper = !use_upper;
				res.char_code = use_upper ? upper_col[code] : lower;
			end
			res.ctrl_held = ctrl_on;
			res.alt_held = alt_on;
			expected_chars.push_back(res);
		end
	endfunction

	// Drive ready: long hold-off on request, steady ready when calm, else random stalls
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			char_bus.ready <= 1'b0;
		end else if (receiver_calm) begin
			char_bus.ready <= 1'b1;
		end else begin
			char_bus.ready <= ($urandom_range(99) >= 28);
		end
	end

	// Compare each result word with the oldest expected character
	always @(posedge clk) begin
		key_char_t want;
		if (arst_n && char_bus.valid && char_bus.ready) begin
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word char %h ctrl %b alt %b", $time,
						char_bus.char_code, char_bus.ctrl_held, char_bus.alt_held);
			end else begin
				want = expected_chars.pop_front();
				if (want.char_code !== char_bus.char_code ||
					want.ctrl_held !== char_bus.ctrl_held ||
					want.alt_held !== char_bus.alt_held) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected char %h ctrl %b alt %b, got char %h ctrl %b alt %b",
							$time, want.char_code, want.ctrl_held, want.alt_held,
							char_bus.char_code, char_bus.ctrl_held, char_bus.alt_held);
				end
			end
		end
	end

	// Offer one scan word after a random gap (none when calm) and hold it until accepted
	task automatic send_scan(input logic [ScanWidth-1:0] scan);
		int gap;
		gap = 0;
		if (!sender_calm)
			while ($urandom_range(99) < 28)
				gap++;
		if (gap > 0) begin
			scan_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_bus.valid <= 1'b1;
		scan_bus.scan_byte <= scan;
		do @(posedge clk); while (!scan_bus.ready);
		translate_scan(scan);
	endtask

	// Stop offering and let every expected character come out
	task automatic wait_drain();
		scan_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_chars.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Extremes, every modifier, zero entries and codes past the table
	task automatic test_directed();
		logic [ScanWidth-1:0] seq[$];
		seq = '{
			8'h00,                 // key code zero, empty entry
			8'h1e,                 // a
			{1'b0, KEY_LSHIFT},
			8'h1e,                 // shifted letter
			8'h02,                 // shifted digit
			{1'b1, KEY_LSHIFT},    // shift toggles again on break
			{1'b0, KEY_CAPS},      // caps make changes nothing
			{1'b1, KEY_CAPS},
			8'h1e,                 // caps letter
			8'h02,                 // caps leaves digits alone
			{1'b0, KEY_RSHIFT},
			8'h1e,                 // shift and caps cancel for letters
			{1'b1, KEY_RSHIFT},
			{1'b0, KEY_CTRL},
			{1'b0, KEY_ALT},
			8'h0e,                 // key without a character
			8'h59,                 // first code past the table
			8'h7f,                 // last code past the table
			8'h9e,                 // plain break
			8'hff,
			8'h80,
			{1'b1, KEY_ALT},
			{1'b1, KEY_CTRL},
			{1'b1, KEY_CAPS},
			8'h47                  // keypad 7
		};
		foreach (seq[i])
			send_scan(seq[i]);
		wait_drain();
	endtask

	// Stall the output long enough to fill the pipe and block the input
	task automatic test_backpressure();
		sender_calm = 1'b1;
		hold_req++;
		repeat (24)
			send_scan({1'b0, 7'($urandom_range(16, 25))});
		sender_calm = 1'b0;
		wait_drain();
	endtask

	// Random typing: mostly key presses and modifier use, some raw noise
	task automatic test_random();
		int                   counted;
		int                   pick;
		logic [CodeWidth-1:0] code;
		logic                 released;
		counted = 0;
		while (counted < RandomKeys) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				{released, code} = 8'($urandom_range(255));
			end else if (pick < 30) begin
				case ($urandom_range(4))
					0: code = KEY_LSHIFT;
					1: code = KEY_RSHIFT;
					2: code = KEY_CTRL;
					3: code = KEY_CAPS;
					default: code = KEY_ALT;
				endcase
				released = 1'($urandom_range(1));
			end else if (pick < 38) begin
				code = 7'($urandom_range(127));
				released = 1'b1;
			end else begin
				if ($urandom_range(9) == 0)
					code = 7'($urandom_range(RomDepth, 127));
				else
					code = 7'($urandom_range(RomDepth - 1));
				released = 1'b0;
			end
			// run a stretch with no idling on either side
			sender_calm = (counted >= 600 && counted < 800);
			receiver_calm = sender_calm;
			send_scan({released, code});
			if (!released || code == KEY_LSHIFT || code == KEY_RSHIFT ||
				code == KEY_CTRL || code == KEY_CAPS || code == KEY_ALT)
				counted++;
			if (counted == 1000 && !released)
				wait_drain();
		end
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		wait_drain();
	endtask

	initial begin
		scan_bus.valid = 1'b0;
		scan_bus.scan_byte = '0;
		char_bus.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sc1a_pkg.sv
src/sc1a_scan_if.sv
src/sc1a_char_if.sv
src/sc1a_xlate.sv
src/scancode_set1_to_ascii_unit.sv
test/testbench.sv
